FILE: rtl/pph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types and constants of the binary PPM header parser.
// ----------------------------------------------------------------------------
package pph_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_MALFORMED  = 3'd2,
    ST_BAD_MAXVAL = 3'd3,
    ST_DEPTH      = 3'd4
  } pph_status_t;

  typedef enum logic [4:0] {
    PH_WAIT    = 5'b00001,
    PH_MAGIC2  = 5'b00010,
    PH_BLANK   = 5'b00100,
    PH_COMMENT = 5'b01000,
    PH_DIGITS  = 5'b10000
  } pph_phase_t;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] BITS_MIN = 5'd8;
  localparam logic [4:0] BITS_MAX = 5'd14;
  localparam logic [31:0] MAXVAL_ONE_BYTE = 32'd255;

  localparam logic [1:0] FIELD_WIDTH  = 2'd0;
  localparam logic [1:0] FIELD_HEIGHT = 2'd1;
  localparam logic [1:0] FIELD_MAXVAL = 2'd2;

  typedef struct packed {
    pph_status_t status;
    logic [4:0]  sample_bits;
    logic [1:0]  sample_bytes;
  } pph_check_t;

  typedef struct packed {
    pph_status_t status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [31:0] max_value;
    logic [4:0]  sample_bits;
    logic [1:0]  sample_bytes;
  } pph_result_t;

endpackage

FILE: rtl/pph_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pph_if
// Valid/ready channels of the PPM header parser: file bytes in, results out.
// ----------------------------------------------------------------------------
interface pph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;
  logic       end_of_data;

  modport source (output valid, in_byte, start_of_file, end_of_data, input ready);
  modport sink   (input valid, in_byte, start_of_file, end_of_data, output ready);
endinterface

interface pph_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [31:0] max_value;
  logic [4:0]  sample_bits;
  logic [1:0]  sample_bytes;

  modport source (output valid, status, image_width, image_height, max_value,
                  sample_bits, sample_bytes, input ready);
  modport sink   (input valid, status, image_width, image_height, max_value,
                  sample_bits, sample_bytes, output ready);
endinterface

FILE: rtl/ppm_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_header_parser
// Parses a binary PPM (P6) header from a byte stream and reports size,
// maxval, bit depth and bytes per sample with a status.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     word
//  in_chan   in   valid/ready   in_byte, start_of_file, end_of_data
//  out_chan  out  valid/ready   status, sizes, maxval, sample_bits/bytes
//
//  One word per cycle sustained while results are taken; the word that causes
//  a result passes the input register, then the result register.
//  The parse state updates once per accepted word, which sets the rate.
//  Synchronous active-low reset clears both registers' valid bits and the
//  parse state. A stalled result holds the input register only when the
//  next word also produces a result; other words keep flowing.
// ----------------------------------------------------------------------------
module ppm_header_parser (
  input  logic    clk,
  input  logic    rst_n,
  pph_in_if.sink  in_chan,
  pph_out_if.source out_chan
);

  logic                 in_valid_r;
  logic [7:0]           byte_r;
  logic                 sof_r;
  logic                 eod_r;
  logic                 out_valid_r;
  pph_pkg::pph_result_t result_r;

  logic                 emit;
  pph_pkg::pph_result_t result;
  logic                 out_free;
  logic                 advance;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign advance       = in_valid_r && (!emit || out_free);
  assign in_chan.ready = !in_valid_r || advance;

  pph_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .in_byte       (byte_r),
    .start_of_file (sof_r),
    .end_of_data   (eod_r),
    .emit          (emit),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.in_byte;
      sof_r  <= in_chan.start_of_file;
      eod_r  <= in_chan.end_of_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_r <= result;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = result_r.status;
  assign out_chan.image_width  = result_r.image_width;
  assign out_chan.image_height = result_r.image_height;
  assign out_chan.max_value    = result_r.max_value;
  assign out_chan.sample_bits  = result_r.sample_bits;
  assign out_chan.sample_bytes = result_r.sample_bytes;

endmodule

FILE: rtl/pph_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pph_check
// Maxval validation: range check, bit depth and bytes per sample.
// ----------------------------------------------------------------------------
module pph_check (
  input  logic [31:0]        max_value,
  output pph_pkg::pph_check_t chk
);

  logic [4:0] len;
  logic [4:0] bits;

  always_comb begin
    len = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (max_value[i]) begin
        len = 5'(i + 1);
      end
    end
    bits = (len < pph_pkg::BITS_MIN) ? pph_pkg::BITS_MIN : len;
  end

  always_comb begin
    if (max_value == 32'd0 || (|max_value[31:16])) begin
      chk.status       = pph_pkg::ST_BAD_MAXVAL;
      chk.sample_bits  = 5'd0;
      chk.sample_bytes = 2'd0;
    end else if (bits > pph_pkg::BITS_MAX) begin
      chk.status       = pph_pkg::ST_DEPTH;
      chk.sample_bits  = bits;
      chk.sample_bytes = 2'd0;
    end else begin
      chk.status       = pph_pkg::ST_OK;
      chk.sample_bits  = bits;
      chk.sample_bytes = (max_value > pph_pkg::MAXVAL_ONE_BYTE) ? 2'd2 : 2'd1;
    end
  end

endmodule

FILE: rtl/pph_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pph_parse
// Header state machine: magic, blanks, comments and three decimal fields.
// ----------------------------------------------------------------------------
module pph_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 start_of_file,
  input  logic                 end_of_data,
  output logic                 emit,
  output pph_pkg::pph_result_t result
);

  pph_pkg::pph_phase_t phase_r, phase_nxt;
  logic [1:0]          field_r, field_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [31:0]         width_r, width_nxt;
  logic [31:0]         height_r, height_nxt;

  logic                is_digit;
  logic                is_blank;
  logic [31:0]         digit_val;
  logic [31:0]         acc_times10;
  pph_pkg::pph_check_t chk;

  pph_check u_check (
    .max_value (acc_r),
    .chk       (chk)
  );

  assign is_digit    = (in_byte >= pph_pkg::CH_ZERO) && (in_byte <= pph_pkg::CH_NINE);
  assign digit_val   = {28'd0, in_byte[3:0]};
  assign acc_times10 = (acc_r << 3) + (acc_r << 1) + digit_val;

  always_comb begin
    is_blank = in_byte inside {pph_pkg::CH_SPACE, pph_pkg::CH_TAB, pph_pkg::CH_LF,
                               pph_pkg::CH_CR, pph_pkg::CH_VT, pph_pkg::CH_FF};
  end

  always_comb begin
    phase_nxt  = phase_r;
    field_nxt  = field_r;
    acc_nxt    = acc_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    emit       = 1'b0;
    result     = '0;

    if (start_of_file) begin
      field_nxt  = pph_pkg::FIELD_WIDTH;
      acc_nxt    = 32'd0;
      width_nxt  = 32'd0;
      height_nxt = 32'd0;
      if (end_of_data || in_byte != pph_pkg::CH_P) begin
        emit          = 1'b1;
        result.status = pph_pkg::ST_BAD_MAGIC;
        phase_nxt     = pph_pkg::PH_WAIT;
      end else begin
        phase_nxt = pph_pkg::PH_MAGIC2;
      end
    end else begin
      case (phase_r)
        pph_pkg::PH_MAGIC2: begin
          if (end_of_data || in_byte != pph_pkg::CH_SIX) begin
            emit          = 1'b1;
            result.status = pph_pkg::ST_BAD_MAGIC;
            phase_nxt     = pph_pkg::PH_WAIT;
          end else begin
            phase_nxt = pph_pkg::PH_BLANK;
          end
        end
        pph_pkg::PH_BLANK: begin
          if (end_of_data || !(is_blank || is_digit || in_byte == pph_pkg::CH_HASH)) begin
            emit          = 1'b1;
            result.status = pph_pkg::ST_MALFORMED;
            phase_nxt     = pph_pkg::PH_WAIT;
          end else if (in_byte == pph_pkg::CH_HASH) begin
            phase_nxt = pph_pkg::PH_COMMENT;
          end else if (is_digit) begin
            acc_nxt   = digit_val;
            phase_nxt = pph_pkg::PH_DIGITS;
          end
        end
        pph_pkg::PH_COMMENT: begin
          if (end_of_data) begin
            emit          = 1'b1;
            result.status = pph_pkg::ST_MALFORMED;
            phase_nxt     = pph_pkg::PH_WAIT;
          end else if (in_byte == pph_pkg::CH_LF || in_byte == pph_pkg::CH_CR) begin
            phase_nxt = pph_pkg::PH_BLANK;
          end
        end
        pph_pkg::PH_DIGITS: begin
          if (!end_of_data && is_digit) begin
            acc_nxt = acc_times10;
          end else if (field_r >= pph_pkg::FIELD_MAXVAL) begin
            emit                = 1'b1;
            result.status       = chk.status;
            result.image_width  = width_r;
            result.image_height = height_r;
            result.max_value    = acc_r;
            result.sample_bits  = chk.sample_bits;
            result.sample_bytes = chk.sample_bytes;
            phase_nxt           = pph_pkg::PH_WAIT;
          end else if (end_of_data) begin
            emit          = 1'b1;
            result.status = pph_pkg::ST_MALFORMED;
            phase_nxt     = pph_pkg::PH_WAIT;
          end else begin
            if (field_r == pph_pkg::FIELD_WIDTH) begin
              width_nxt = acc_r;
            end else begin
              height_nxt = acc_r;
            end
            field_nxt = field_r + 2'd1;
            acc_nxt   = 32'd0;
            phase_nxt = pph_pkg::PH_BLANK;
          end
        end
        default: begin
          phase_nxt = pph_pkg::PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pph_pkg::PH_WAIT;
      field_r  <= 2'd0;
      acc_r    <= 32'd0;
      width_r  <= 32'd0;
      height_r <= 32'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      field_r  <= field_nxt;
      acc_r    <= acc_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

endmodule

FILE: rtl/pph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pph_checker
// Port-level checks of the PPM header parser, bound to the top level.
// ----------------------------------------------------------------------------
module pph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] image_width,
  input logic [31:0] image_height,
  input logic [31:0] max_value,
  input logic [4:0]  sample_bits,
  input logic [1:0]  sample_bytes
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(max_value))
    else $error("stalled result word changed");

  a_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == pph_pkg::ST_OK |->
      sample_bits >= pph_pkg::BITS_MIN && sample_bits <= pph_pkg::BITS_MAX &&
      (sample_bytes == 2'd2) == (max_value > pph_pkg::MAXVAL_ONE_BYTE) &&
      sample_bytes != 2'd0)
    else $error("ok result with inconsistent depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == pph_pkg::ST_BAD_MAGIC || status == pph_pkg::ST_MALFORMED) |->
      image_width == 32'd0 && image_height == 32'd0 && max_value == 32'd0 &&
      sample_bits == 5'd0 && sample_bytes == 2'd0)
    else $error("failed header with nonzero fields");

endmodule

bind ppm_header_parser pph_checker u_pph_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .image_width  (out_chan.image_width),
  .image_height (out_chan.image_height),
  .max_value    (out_chan.max_value),
  .sample_bits  (out_chan.sample_bits),
  .sample_bytes (out_chan.sample_bytes)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams of binary PPM files into the header parser. A short
// table of hand-built words with expected results comes first, then random
// files, most well formed and the rest truncated, corrupted or plain noise,
// whose headers are checked against a parser model kept in this bench.
// ----------------------------------------------------------------------------
module testbench;
  import pph_pkg::*;

  localparam logic [31:0] MAXVAL_LIMIT = 32'd65535;

  typedef struct packed {
    logic [7:0]  data;
    logic        sof;
    logic        eod;
    logic        typed;
    pph_result_t want;
  } plan_row_t;

  localparam pph_result_t NO_RESULT = '0;
  localparam pph_result_t BAD_MAGIC_R = '{ST_BAD_MAGIC, 32'd0, 32'd0, 32'd0, 5'd0, 2'd0};
  localparam pph_result_t MALFORMED_R = '{ST_MALFORMED, 32'd0, 32'd0, 32'd0, 5'd0, 2'd0};
  localparam int DIRECTED_ROWS = 26;

  localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'hff,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00,   1'b1, 1'b1, 1'b1, BAD_MAGIC_R},
    '{8'h51,   1'b1, 1'b0, 1'b1, BAD_MAGIC_R},
    '{CH_P,    1'b1, 1'b0, 1'b0, NO_RESULT},
    '{8'h00,   1'b0, 1'b1, 1'b1, BAD_MAGIC_R},
    '{CH_P,    1'b1, 1'b0, 1'b0, NO_RESULT},
    '{CH_SIX,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_HASH, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'hff,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_CR,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_VT,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h31,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_HASH, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h32,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_FF,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_ZERO, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00,   1'b0, 1'b1, 1'b1,
      '{ST_BAD_MAXVAL, 32'd1, 32'd2, 32'd0, 5'd0, 2'd0}},
    '{8'h80,   1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_P,    1'b1, 1'b0, 1'b0, NO_RESULT},
    '{CH_SIX,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h21,   1'b0, 1'b0, 1'b1, MALFORMED_R},
    '{CH_P,    1'b1, 1'b0, 1'b0, NO_RESULT},
    '{CH_P,    1'b1, 1'b0, 1'b0, NO_RESULT},
    '{CH_SIX,  1'b0, 1'b0, 1'b0, NO_RESULT},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{8'h00,   1'b0, 1'b1, 1'b1, MALFORMED_R}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pph_in_if  in_chan ();
  pph_out_if out_chan ();

  ppm_header_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  plan_row_t   byte_plan [$];
  plan_row_t   draft [$];
  pph_result_t pending_headers [$];
  plan_row_t   cur_word;
  int unsigned total_words;
  int unsigned words_sent;
  int unsigned headers_checked;
  int unsigned error_count;
  int unsigned status_seen [0:4];
  int unsigned cyc;

  pph_phase_t  p_phase;
  logic [1:0]  p_field;
  logic [31:0] p_acc;
  logic [31:0] p_width;
  logic [31:0] p_height;

  bit          got_header;
  pph_result_t header_out;

  function automatic pph_result_t mk_result(pph_status_t st, logic [31:0] w, logic [31:0] h,
                                            logic [31:0] m, logic [4:0] bits,
                                            logic [1:0] nbytes);
    pph_result_t r;
    r.status       = st;
    r.image_width  = w;
    r.image_height = h;
    r.max_value    = m;
    r.sample_bits  = bits;
    r.sample_bytes = nbytes;
    return r;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_VT || c == CH_FF;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic parse_word(input plan_row_t w, output bit has, output pph_result_t r);
    logic [7:0]  c;
    logic [31:0] m;
    int          len;
    c   = w.data;
    has = 1'b0;
    r   = NO_RESULT;
    if (w.sof) begin
      p_field  = FIELD_WIDTH;
      p_acc    = '0;
      p_width  = '0;
      p_height = '0;
      if (w.eod || c != CH_P) begin
        has = 1'b1;
        r   = BAD_MAGIC_R;
      end else begin
        p_phase = PH_MAGIC2;
      end
    end else begin
      case (p_phase)
        PH_MAGIC2: begin
          if (w.eod || c != CH_SIX) begin
            has = 1'b1;
            r   = BAD_MAGIC_R;
          end else begin
            p_phase = PH_BLANK;
          end
        end
        PH_BLANK: begin
          if (w.eod) begin
            has = 1'b1;
            r   = MALFORMED_R;
          end else if (is_blank(c)) begin
          end else if (c == CH_HASH) begin
            p_phase = PH_COMMENT;
          end else if (is_digit(c)) begin
            p_acc   = 32'(c - CH_ZERO);
            p_phase = PH_DIGITS;
          end else begin
            has = 1'b1;
            r   = MALFORMED_R;
          end
        end
        PH_COMMENT: begin
          if (w.eod) begin
            has = 1'b1;
            r   = MALFORMED_R;
          end else if (c == CH_LF || c == CH_CR) begin
            p_phase = PH_BLANK;
          end
        end
        PH_DIGITS: begin
          if (!w.eod && is_digit(c)) begin
            p_acc = p_acc * 32'd10 + 32'(c - CH_ZERO);
          end else if (p_field >= FIELD_MAXVAL) begin
            has = 1'b1;
            m   = p_acc;
            if (m == 0 || m > MAXVAL_LIMIT) begin
              r = mk_result(ST_BAD_MAXVAL, p_width, p_height, m, 5'd0, 2'd0);
            end else begin
              len = 0;
              for (int i = 0; i < 32; i++) begin
                if (m[i]) len = i + 1;
              end
              if (len < BITS_MIN) len = BITS_MIN;
              if (len > BITS_MAX) begin
                r = mk_result(ST_DEPTH, p_width, p_height, m, 5'(len), 2'd0);
              end else begin
                r = mk_result(ST_OK, p_width, p_height, m, 5'(len),
                              (m > MAXVAL_ONE_BYTE) ? 2'd2 : 2'd1);
              end
            end
          end else if (w.eod) begin
            has = 1'b1;
            r   = MALFORMED_R;
          end else begin
            if (p_field == FIELD_WIDTH) p_width = p_acc;
            else p_height = p_acc;
            p_field = p_field + 2'd1;
            p_acc   = '0;
            p_phase = PH_BLANK;
          end
        end
        default: p_phase = PH_WAIT;
      endcase
    end
    if (has) p_phase = PH_WAIT;
  endtask

  task automatic check_header(pph_result_t want);
    if (out_chan.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_chan.status);
      error_count++;
    end
    if (out_chan.image_width !== want.image_width) begin
      $error("image_width: expected %0d, got %0d", want.image_width, out_chan.image_width);
      error_count++;
    end
    if (out_chan.image_height !== want.image_height) begin
      $error("image_height: expected %0d, got %0d", want.image_height,
             out_chan.image_height);
      error_count++;
    end
    if (out_chan.max_value !== want.max_value) begin
      $error("max_value: expected %0d, got %0d", want.max_value, out_chan.max_value);
      error_count++;
    end
    if (out_chan.sample_bits !== want.sample_bits) begin
      $error("sample_bits: expected %0d, got %0d", want.sample_bits, out_chan.sample_bits);
      error_count++;
    end
    if (out_chan.sample_bytes !== want.sample_bytes) begin
      $error("sample_bytes: expected %0d, got %0d", want.sample_bytes,
             out_chan.sample_bytes);
      error_count++;
    end
  endtask

  task automatic push_word(logic [7:0] d, logic s, logic e);
    plan_row_t w;
    w.data  = d;
    w.sof   = s;
    w.eod   = e;
    w.typed = 1'b0;
    w.want  = NO_RESULT;
    draft.push_back(w);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      4:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] pick_nondigit();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (is_digit(c)) c = c + 8'd16;
    return c;
  endfunction

  function automatic logic [7:0] pick_terminator();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return pick_blank();
    if (r == 6) return CH_HASH;
    if (r == 7) return pick_nondigit();
    return CH_LF;
  endfunction

  task automatic push_separator();
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_word(CH_HASH, 1'b0, 1'b0);
        repeat ($urandom_range(0, 4)) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_LF || c == CH_CR) c = 8'h7f;
          push_word(c, 1'b0, 1'b0);
        end
        push_word($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0, 1'b0);
      end else begin
        push_word(pick_blank(), 1'b0, 1'b0);
      end
    end
  endtask

  task automatic push_field(int idx);
    logic [63:0] v;
    logic [7:0]  digits [$];
    bit          wrap;
    int          r;
    wrap = 1'b0;
    v    = 0;
    r    = $urandom_range(0, 9);
    if (idx < 2) begin
      if (r < 7) v = 64'($urandom_range(1, 4096));
      else if (r == 7) v = 64'($urandom_range(0, 9));
      else if (r == 8) v = 64'($urandom);
      else wrap = 1'b1;
    end else begin
      case (r)
        0: v = 0;
        1: v = 64'($urandom_range(1, 255));
        2: v = 64'($urandom_range(256, 16383));
        3: v = 64'($urandom_range(16384, 65535));
        4: v = $urandom_range(0, 1) ? 64'($urandom_range(65536, 1000000)) : 64'($urandom);
        5: wrap = 1'b1;
        6: v = 64'($urandom_range(1, 7));
        7: begin
          case ($urandom_range(0, 6))
            0: v = 1;
            1: v = 255;
            2: v = 256;
            3: v = 16383;
            4: v = 16384;
            5: v = 65535;
            default: v = 65536;
          endcase
        end
        default: v = 64'($urandom_range(1, 1023));
      endcase
    end
    if (wrap) begin
      repeat ($urandom_range(10, 12)) push_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b0);
    end else begin
      do begin
        digits.push_front(CH_ZERO + 8'(v % 10));
        v = v / 10;
      end while (v != 0);
      if ($urandom_range(0, 7) == 0) digits.push_front(CH_ZERO);
      foreach (digits[i]) push_word(digits[i], 1'b0, 1'b0);
    end
    if (idx == 2 && $urandom_range(0, 1) == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else push_word(pick_terminator(), 1'b0, 1'b0);
  endtask

  task automatic add_file();
    int         fate;
    int         cut;
    int         pos;
    logic [7:0] c;
    fate = $urandom_range(0, 99);
    draft.delete();
    if (fate < 4) begin
      push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else if (fate < 8) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_P) c = 8'h70;
      push_word(c, 1'b1, 1'b0);
    end else begin
      push_word(CH_P, 1'b1, 1'b0);
      if (fate < 12) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_SIX) c = 8'h33;
        push_word(c, 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        push_word(CH_SIX, 1'b0, 1'b0);
        for (int f = 0; f < 3; f++) begin
          push_separator();
          push_field(f);
        end
        if (fate < 22) begin
          cut = $urandom_range(1, draft.size() - 1);
          while (draft.size() > cut) void'(draft.pop_back());
          if ($urandom_range(0, 1)) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else if (fate < 28) begin
          pos = $urandom_range(1, draft.size() - 1);
          draft[pos].data = 8'($urandom_range(0, 255));
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        push_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
    foreach (draft[i]) byte_plan.push_back(draft[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      out_chan.ready <= 1'b0;
      cyc            <= 0;
      p_phase        = PH_WAIT;
      p_field        = FIELD_WIDTH;
      p_acc          = '0;
      p_width        = '0;
      p_height       = '0;
    end else begin
      cyc <= cyc + 1;
      if (in_chan.valid && in_chan.ready) begin
        parse_word(cur_word, got_header, header_out);
        words_sent++;
        if (cur_word.typed) pending_headers.push_back(cur_word.want);
        else if (got_header) pending_headers.push_back(header_out);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_headers.size() == 0) begin
          $error("header reported with none pending: status %0d", out_chan.status);
          error_count++;
        end else begin
          header_out = pending_headers.pop_front();
          check_header(header_out);
          headers_checked++;
          if (header_out.status <= ST_DEPTH) status_seen[header_out.status]++;
        end
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (byte_plan.size() > 0 &&
            ((cyc >= 200 && cyc < 400) || $urandom_range(0, 99) >= 10)) begin
          cur_word              = byte_plan.pop_front();
          in_chan.valid         <= 1'b1;
          in_chan.in_byte       <= cur_word.data;
          in_chan.start_of_file <= cur_word.sof;
          in_chan.end_of_data   <= cur_word.eod;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      out_chan.ready <= (cyc >= 200 && cyc < 400) || $urandom_range(0, 99) >= 10;
    end
  end

  initial begin
    in_chan.valid         = 1'b0;
    in_chan.in_byte       = 8'h00;
    in_chan.start_of_file = 1'b0;
    in_chan.end_of_data   = 1'b0;
    out_chan.ready        = 1'b0;
    words_sent            = 0;
    headers_checked       = 0;
    error_count           = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (DIRECTED[i]) byte_plan.push_back(DIRECTED[i]);
    while (byte_plan.size() < DIRECTED_ROWS + 500) add_file();
    total_words = byte_plan.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (words_sent < total_words) @(posedge clk);
    while (pending_headers.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("drove %0d words, checked %0d headers", words_sent, headers_checked);
    $display("status mix: ok %0d, bad magic %0d, malformed %0d, bad maxval %0d, depth %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
